/* rtl/hpfm_pkg.sv */
// hpfm_pkg: shared types and constants of the hysteresis period frequency meter
// depends on nothing; used by hpfm_div and hysteresis_period_frequency_meter
`default_nettype none

package hpfm_pkg;

  localparam int unsigned CntW  = 32;
  localparam int unsigned PerW  = 24;
  localparam int unsigned FreqW = 16;
  localparam int unsigned FiltW = 19;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegThreshold  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHysteresis = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinPeriod  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxPeriod  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTimeout    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSampleRate = 3'd5;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdRead   = 1'b1;

  typedef struct packed {
    logic            start;
    logic [PerW-1:0] dividend;
    logic [PerW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [PerW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/hysteresis_period_frequency_meter.sv */
// hysteresis_period_frequency_meter: schmitt comparator, period tracking and
// smoothed reciprocal frequency; depends on hpfm_pkg and hpfm_div
//
//   channel | signals                                   | direction
//   in      | in_valid_i, in_stall_o, cmd_i, sample_i   | item in
//   out     | out_valid_o, out_stall_i, frequency_hz_o,  | result out
//           | valid_res_o, signal_high_o                |
//   cfg     | cfg_we_i, cfg_index_i, cfg_data_i         | register write
//
// a sample item, or a read that finds no live signal, is answered at its
// accept edge; a live read runs 24 restoring divider steps, registers
// the quotient, then loads the filtered result once the output is free
// reset clears the count, rise position, period, comparator and filter
// an item is taken only when idle and the output register is free or being emptied
`default_nettype none

module hysteresis_period_frequency_meter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic [7:0]                    sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [hpfm_pkg::FreqW-1:0]         frequency_hz_o,
  output logic                               valid_res_o,
  output logic                               signal_high_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [hpfm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [hpfm_pkg::PerW-1:0]     cfg_data_i
);

  localparam int unsigned CW = hpfm_pkg::CntW;
  localparam int unsigned PW = hpfm_pkg::PerW;
  localparam int unsigned FW = hpfm_pkg::FiltW;
  localparam int unsigned QW = hpfm_pkg::FreqW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FILT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [7:0]    thr_q;
  logic [6:0]    hyst_q;
  logic [PW-1:0] min_q, max_q, tmo_q, rate_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rise_q, rise_d;
  logic [PW-1:0] per_q, per_d;
  logic          high_q, high_d;
  logic [FW-1:0] filt_q, filt_d;
  logic [QW-1:0] raw_q, raw_d;

  logic          ovalid_q, ovalid_d;
  logic [QW-1:0] ofreq_q, ofreq_d;
  logic          ores_q, ores_d;

  logic          can_load, in_acc;
  logic [7:0]    hi_lvl, lo_lvl;
  logic [CW-1:0] cnt_inc, per_new, since;
  logic          live;
  logic [FW-1:0] target;
  logic [FW:0]   diff, step;
  logic [FW-1:0] filt_new;

  hpfm_pkg::div_req_t div_req;
  hpfm_pkg::div_rsp_t div_rsp;

  hpfm_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign can_load   = !ovalid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && can_load);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign hi_lvl  = thr_q + {1'b0, hyst_q};
  assign lo_lvl  = thr_q - {1'b0, hyst_q};
  assign cnt_inc = cnt_q + CW'(1);
  assign per_new = cnt_inc - rise_q;
  assign since   = cnt_q - rise_q;
  assign live    = (since < {{(CW-PW){1'b0}}, tmo_q}) && (per_q != '0);

  assign target   = {raw_q, 3'b000};
  assign diff     = {1'b0, target} - {1'b0, filt_q};
  // arithmetic shift rounded toward zero
  assign step     = $signed(diff + (diff[FW] ? (FW+1)'(3) : (FW+1)'(0))) >>> 2;
  assign filt_new = (filt_q == '0) ? target : (filt_q + step[FW-1:0]);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = rate_q;
    div_req.divisor  = per_q;
    state_d  = state_q;
    cnt_d    = cnt_q;
    rise_d   = rise_q;
    per_d    = per_q;
    high_d   = high_q;
    filt_d   = filt_q;
    raw_d    = raw_q;
    ovalid_d = ovalid_q && out_stall_i;
    ofreq_d  = ofreq_q;
    ores_d   = ores_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_i == hpfm_pkg::CmdSample) begin
            cnt_d = cnt_inc;
            if (!high_q) begin
              if (sample_i >= hi_lvl) begin
                high_d = 1'b1;
                rise_d = cnt_inc;
                if ((per_new >= {{(CW-PW){1'b0}}, min_q}) &&
                    (per_new <= {{(CW-PW){1'b0}}, max_q})) begin
                  per_d = per_new[PW-1:0];
                end
              end
            end else if (sample_i <= lo_lvl) begin
              high_d = 1'b0;
            end
            ovalid_d = 1'b1;
            ofreq_d  = '0;
            ores_d   = 1'b0;
          end else if (!live) begin
            filt_d   = '0;
            ovalid_d = 1'b1;
            ofreq_d  = '0;
            ores_d   = 1'b0;
          end else begin
            div_req.start = 1'b1;
            state_d       = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          raw_d   = div_rsp.quotient[QW-1:0];
          state_d = S_FILT;
        end
      end
      S_FILT: begin
        if (can_load) begin
          filt_d   = filt_new;
          ovalid_d = 1'b1;
          ofreq_d  = filt_new[FW-1:3];
          ores_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      thr_q    <= 8'd128;
      hyst_q   <= 7'd8;
      min_q    <= PW'(2);
      max_q    <= PW'(4096);
      tmo_q    <= PW'(38461);
      rate_q   <= PW'(38461);
      cnt_q    <= '0;
      rise_q   <= '0;
      per_q    <= '0;
      high_q   <= 1'b0;
      filt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rise_q   <= rise_d;
      per_q    <= per_d;
      high_q   <= high_d;
      filt_q   <= filt_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          hpfm_pkg::RegThreshold:  thr_q  <= cfg_data_i[7:0];
          hpfm_pkg::RegHysteresis: hyst_q <= cfg_data_i[6:0];
          hpfm_pkg::RegMinPeriod:  min_q  <= cfg_data_i;
          hpfm_pkg::RegMaxPeriod:  max_q  <= cfg_data_i;
          hpfm_pkg::RegTimeout:    tmo_q  <= cfg_data_i;
          hpfm_pkg::RegSampleRate: rate_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q   <= raw_d;
    ofreq_q <= ofreq_d;
    ores_q  <= ores_d;
  end

  assign out_valid_o    = ovalid_q;
  assign frequency_hz_o = ofreq_q;
  assign valid_res_o    = ores_q;
  assign signal_high_o  = high_q;

  a_live_read_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == hpfm_pkg::CmdRead) && live) |=> (state_q == S_DIV))
    else $error("live read did not start the divider");

  a_div_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == S_DIV))
    else $error("divider busy outside the divide state");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !ores_q) |-> (ofreq_q == '0))
    else $error("non-valid result carries a frequency");

  a_sample_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == hpfm_pkg::CmdSample)) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("sample item did not advance the count");

endmodule

`default_nettype wire

/* rtl/hpfm_div.sv */
// hpfm_div: restoring divider, one subtract and compare per cycle
// depends on hpfm_pkg for widths and the request and response structs
`default_nettype none

module hpfm_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hpfm_pkg::div_req_t req_i,
  output hpfm_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned W  = hpfm_pkg::PerW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    trial   = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q)
    else $error("divider not busy after start");

  a_nonzero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.divisor != '0)
    else $error("divider started with zero divisor");

endmodule

`default_nettype wire

/* sim/tb_hysteresis_period_frequency_meter.sv */
// tb_hysteresis_period_frequency_meter: self-checking bench for the period frequency meter
// drives sample and read items through random gaps and stalls, checks each result
// against an in-bench model; depends on hpfm_pkg and the rtl of the block
`default_nettype none

module tb_hysteresis_period_frequency_meter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned CntW    = hpfm_pkg::CntW;
  localparam int unsigned PerW    = hpfm_pkg::PerW;
  localparam int unsigned FreqW   = hpfm_pkg::FreqW;
  localparam int unsigned FiltW   = hpfm_pkg::FiltW;
  localparam int unsigned CfgIdxW = hpfm_pkg::CfgIdxW;

  typedef struct packed {
    logic       cmd;
    logic [7:0] smp;
  } meter_item_t;

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic             valid;
    logic             high;
  } meter_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                cmd_i = hpfm_pkg::CmdSample;
  logic [7:0]          sample_i = 8'd0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [FreqW-1:0]    frequency_hz_o;
  logic                valid_res_o;
  logic                signal_high_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = hpfm_pkg::RegThreshold;
  logic [PerW-1:0]     cfg_data_i = '0;

  hysteresis_period_frequency_meter u_dut (.*);

  // model copy of registers and state
  logic [7:0]       m_threshold = 8'd128;
  logic [6:0]       m_hysteresis = 7'd8;
  logic [PerW-1:0]  m_min = 24'd2;
  logic [PerW-1:0]  m_max = 24'd4096;
  logic [PerW-1:0]  m_timeout = 24'd38461;
  logic [PerW-1:0]  m_rate = 24'd38461;
  logic [CntW-1:0]  m_count = '0;
  logic [CntW-1:0]  m_last_rise = '0;
  logic [PerW-1:0]  m_period = '0;
  logic             m_high = 1'b0;
  logic [FiltW-1:0] m_filt = '0;

  meter_item_t   items_pending[$];
  meter_result_t meter_results_due[$];
  meter_item_t   next_item;
  meter_result_t due;
  int            errors = 0;
  int            n_pushed = 0;
  int            n_results = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  int unsigned   quiet = 0;
  bit            calm = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic meter_step(input logic cmd, input logic [7:0] smp);
    logic [7:0]       hi_lvl, lo_lvl;
    logic [CntW-1:0]  since, per;
    logic [PerW-1:0]  quot;
    logic [FiltW-1:0] target;
    int               diff;
    meter_result_t    r;
    r = '0;
    if (cmd == hpfm_pkg::CmdSample) begin
      hi_lvl = m_threshold + m_hysteresis;
      lo_lvl = m_threshold - m_hysteresis;
      m_count = m_count + 1;
      if (!m_high) begin
        if (smp >= hi_lvl) begin
          per = m_count - m_last_rise;
          m_high = 1'b1;
          m_last_rise = m_count;
          if (per >= m_min && per <= m_max) m_period = per[PerW-1:0];
        end
      end else if (smp <= lo_lvl) begin
        m_high = 1'b0;
      end
    end else begin
      since = m_count - m_last_rise;
      if (since >= m_timeout || m_period == '0) begin
        m_filt = '0;
      end else begin
        quot = m_rate / m_period;
        target = {quot[FreqW-1:0], 3'b000};
        if (m_filt == '0) begin
          m_filt = target;
        end else begin
          diff = int'(target) - int'(m_filt);
          m_filt = FiltW'(int'(m_filt) + diff / 4);
        end
        r.freq = m_filt[FiltW-1:3];
        r.valid = 1'b1;
      end
    end
    r.high = m_high;
    meter_results_due.push_back(r);
  endtask

  task automatic push_item(input logic cmd, input logic [7:0] smp);
    items_pending.push_back('{cmd: cmd, smp: smp});
    n_pushed++;
  endtask

  // well-formed square-ish wave, rise every period samples, reads sprinkled in
  task automatic push_wave(input int period, input int n_cycles);
    logic [7:0] hi_lvl, lo_lvl, up_min, dn_max, s;
    int         c, k, hi_len;
    hi_lvl = m_threshold + m_hysteresis;
    lo_lvl = m_threshold - m_hysteresis;
    up_min = (lo_lvl != 8'hFF) ? lo_lvl + 8'd1 : 8'hFF;
    dn_max = (hi_lvl != 8'd0) ? hi_lvl - 8'd1 : 8'd0;
    for (c = 0; c < n_cycles; c++) begin
      hi_len = $urandom_range(1, period - 1);
      for (k = 0; k < period; k++) begin
        if (k == 0) s = 8'($urandom_range(hi_lvl, 255));
        else if (k < hi_len) s = 8'($urandom_range(up_min, 255));
        else if (k == hi_len) s = 8'($urandom_range(0, lo_lvl));
        else s = 8'($urandom_range(0, dn_max));
        push_item(hpfm_pkg::CmdSample, s);
        if ($urandom_range(0, 99) < 12) push_item(hpfm_pkg::CmdRead, 8'($urandom));
      end
    end
  endtask

  task automatic push_random(input int n);
    int stop_at, period, k;
    stop_at = n_pushed + n;
    while (n_pushed < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        period = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 400) : $urandom_range(2, 24);
        push_wave(period, (period > 24) ? 1 : $urandom_range(1, 6));
      end else begin
        for (k = $urandom_range(1, 12); k > 0; k--)
          push_item(($urandom_range(0, 9) < 3) ? hpfm_pkg::CmdRead : hpfm_pkg::CmdSample,
                    8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PerW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      hpfm_pkg::RegThreshold:  m_threshold = data[7:0];
      hpfm_pkg::RegHysteresis: m_hysteresis = data[6:0];
      hpfm_pkg::RegMinPeriod:  m_min = data;
      hpfm_pkg::RegMaxPeriod:  m_max = data;
      hpfm_pkg::RegTimeout:    m_timeout = data;
      hpfm_pkg::RegSampleRate: m_rate = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] thr, input logic [6:0] hyst,
                            input logic [PerW-1:0] min_p, input logic [PerW-1:0] max_p,
                            input logic [PerW-1:0] tmo, input logic [PerW-1:0] rate);
    write_reg(hpfm_pkg::RegThreshold, PerW'(thr));
    write_reg(hpfm_pkg::RegHysteresis, PerW'(hyst));
    write_reg(hpfm_pkg::RegMinPeriod, min_p);
    write_reg(hpfm_pkg::RegMaxPeriod, max_p);
    write_reg(hpfm_pkg::RegTimeout, tmo);
    write_reg(hpfm_pkg::RegSampleRate, rate);
  endtask

  task automatic wait_idle();
    while (items_pending.size() != 0 || in_valid_i || meter_results_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // item driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) meter_step(cmd_i, sample_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (items_pending.size() != 0) begin
          next_item = items_pending.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= next_item.cmd;
          sample_i <= next_item.smp;
          gap_left = calm ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (meter_results_due.size() == 0) begin
          $error("result with nothing outstanding: freq %0d valid %0d high %0d",
                 frequency_hz_o, valid_res_o, signal_high_o);
          errors++;
        end else begin
          due = meter_results_due.pop_front();
          if (frequency_hz_o !== due.freq) begin
            $error("frequency_hz: expected %0d, got %0d", due.freq, frequency_hz_o);
            errors++;
          end
          if (valid_res_o !== due.valid) begin
            $error("valid_res: expected %0d, got %0d", due.valid, valid_res_o);
            errors++;
          end
          if (signal_high_o !== due.high) begin
            $error("signal_high: expected %0d, got %0d", due.high, signal_high_o);
            errors++;
          end
        end
        // long hold so the block backs up and stalls its input
        if (n_results == 300 || n_results == 1200) stall_left = 250;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("** hysteresis_period_frequency_meter: FAILED **");
      $finish;
    end
  end

  initial begin
    int phase;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default levels 136 and 120
    push_item(hpfm_pkg::CmdRead, 8'h00);
    push_item(hpfm_pkg::CmdSample, 8'd255);
    push_item(hpfm_pkg::CmdRead, 8'hFF);
    push_item(hpfm_pkg::CmdSample, 8'd0);
    push_item(hpfm_pkg::CmdSample, 8'd136);
    push_item(hpfm_pkg::CmdRead, 8'h00);
    push_item(hpfm_pkg::CmdRead, 8'h00);
    push_item(hpfm_pkg::CmdSample, 8'd121);
    push_item(hpfm_pkg::CmdSample, 8'd120);
    push_item(hpfm_pkg::CmdSample, 8'd135);
    push_item(hpfm_pkg::CmdSample, 8'd200);
    push_item(hpfm_pkg::CmdRead, 8'h00);
    push_item(hpfm_pkg::CmdSample, 8'd0);
    push_item(hpfm_pkg::CmdSample, 8'd255);
    push_item(hpfm_pkg::CmdRead, 8'h00);
    push_item(hpfm_pkg::CmdRead, 8'h00);
    push_random(150);

    for (phase = 1; phase < 8; phase++) begin
      wait_idle();
      calm = (phase == 3 || phase == 6);
      case (phase)
        1: set_config(8'd250, 7'd10, 24'd2, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        2: set_config(8'd0, 7'd127, 24'd40, 24'd10, 24'd500, 24'd12345);
        3: set_config(8'd255, 7'd0, 24'd1, 24'd50, 24'd60, 24'd1);
        4: set_config(8'd0, 7'd0, 24'd2, 24'd30, 24'd1, 24'd1000);
        5: set_config(8'd100, 7'd20, 24'd3, 24'd200, 24'd300, 24'd50000);
        default: set_config(8'($urandom), 7'($urandom), PerW'($urandom_range(1, 6)),
                            ($urandom_range(0, 3) == 0) ? PerW'($urandom_range(1, 24'hFFFFFF))
                                                        : PerW'($urandom_range(6, 300)),
                            ($urandom_range(0, 3) == 0) ? PerW'($urandom_range(1, 24'hFFFFFF))
                                                        : PerW'($urandom_range(20, 2000)),
                            PerW'($urandom_range(1, 24'hFFFFFF)));
      endcase
      push_random(135);
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (meter_results_due.size() != 0) begin
      $error("%0d results never arrived", meter_results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("** hysteresis_period_frequency_meter: PASSED **");
    end else begin
      $display("** hysteresis_period_frequency_meter: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/hpfm_pkg.sv
rtl/hpfm_div.sv
rtl/hysteresis_period_frequency_meter.sv
sim/tb_hysteresis_period_frequency_meter.sv
